>>> rtl/zctpim_pkg.sv
// Package for the ZCT plane index mapper: widths, register indexes,
// error codes, dimension order decode and pipeline sideband types.
// No dependencies.
package zctpim_pkg;

  localparam int SW       = 16;
  localparam int IW       = 32;
  localparam int ERRW     = 4;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam int IN_DW    = 128;
  localparam int IN_UW    = 1;
  localparam int OUT_DW   = 184;

  localparam logic [2:0] ORD_XYZCT = 3'd0;
  localparam logic [2:0] ORD_XYZTC = 3'd1;
  localparam logic [2:0] ORD_XYCZT = 3'd2;
  localparam logic [2:0] ORD_XYCTZ = 3'd3;
  localparam logic [2:0] ORD_XYTZC = 3'd4;
  localparam logic [2:0] ORD_XYTCZ = 3'd5;

  localparam logic ACT_FORWARD = 1'b0;

  typedef enum logic [CFG_AW-1:0] {
    REG_DIM_ORDER,
    REG_Z_SIZE,
    REG_C_SIZE,
    REG_T_SIZE,
    REG_Z_SUB_SIZE,
    REG_C_SUB_SIZE,
    REG_T_SUB_SIZE,
    REG_IMAGE_COUNT
  } reg_e;

  typedef enum logic [ERRW-1:0] {
    ERR_OK,
    ERR_Z_SIZE,
    ERR_T_SIZE,
    ERR_C_SIZE,
    ERR_COUNT,
    ERR_MISMATCH,
    ERR_Z_RANGE,
    ERR_T_RANGE,
    ERR_C_RANGE
  } err_e;

  typedef enum logic [1:0] {
    DIM_Z,
    DIM_C,
    DIM_T
  } dim_e;

  typedef struct packed {
    dim_e s2;
    dim_e s1;
    dim_e s0;
  } slots_t;

  typedef struct packed {
    err_e          err;
    logic          action;
    logic [IW-1:0] fidx;
  } side_t;

  typedef struct packed {
    side_t         base;
    logic [SW-1:0] r1;
  } side2_t;

  function automatic slots_t order_slots(logic [2:0] ord);
    slots_t s;
    case (ord)
      ORD_XYZTC: s = '{s0: DIM_Z, s1: DIM_T, s2: DIM_C};
      ORD_XYCZT: s = '{s0: DIM_C, s1: DIM_Z, s2: DIM_T};
      ORD_XYCTZ: s = '{s0: DIM_C, s1: DIM_T, s2: DIM_Z};
      ORD_XYTZC: s = '{s0: DIM_T, s1: DIM_Z, s2: DIM_C};
      ORD_XYTCZ: s = '{s0: DIM_T, s1: DIM_C, s2: DIM_Z};
      default:   s = '{s0: DIM_Z, s1: DIM_C, s2: DIM_T};
    endcase
    return s;
  endfunction

endpackage

>>> rtl/zctpim_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes sharing one
// valid and one sideband word. Stand-alone, no package needed. The user must hold the
// divisor input steady while items are in flight; the divider does not enforce it.
module zctpim_div #(
  parameter int LANES  = 1,
  parameter int DW     = 32,
  parameter int SW     = 16,
  parameter int SIDE_W = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [LANES-1:0][DW-1:0]    dividend_i,
  input  logic [LANES-1:0][SW-1:0]    divisor_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic [LANES-1:0][DW-1:0]    quot_o,
  output logic [LANES-1:0][SW-1:0]    rem_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int AW = SW + DW;

  logic [DW-1:0]                    v_q;
  logic [DW-1:0][LANES-1:0][AW-1:0] a_q;
  logic [DW-1:0][LANES-1:0][AW-1:0] a_d;
  logic [DW-1:0][SIDE_W-1:0]        side_q;

  function automatic logic [AW-1:0] div_step(logic [AW-1:0] a, logic [SW-1:0] d);
    logic [AW:0]   t;
    logic [SW:0]   up;
    logic          hit;
    t   = {a, 1'b0};
    up  = t[AW:DW];
    hit = (up >= {1'b0, d});
    if (hit) begin
      up = up - {1'b0, d};
    end
    return {up[SW-1:0], t[DW-1:1], hit};
  endfunction

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      a_d[0][l] = div_step({{SW{1'b0}}, dividend_i[l]}, divisor_i[l]);
      for (int k = 1; k < DW; k++) begin
        a_d[k][l] = div_step(a_q[k-1][l], divisor_i[l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_d;
      side_q <= {side_q[DW-2:0], side_i};
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quot_o[l] = a_q[DW-1][l][DW-1:0];
      rem_o[l]  = a_q[DW-1][l][AW-1:DW];
    end
  end

  assign valid_o = v_q[DW-1];
  assign side_o  = side_q[DW-1];

endmodule

>>> rtl/zct_plane_index_mapper_top.sv
// ZCT plane index mapper, top level: three arithmetic stages, three
// chained 32-stage divider pipelines and one output register.
// One request is taken every cycle while the pipeline advances; the whole
// pipeline advances whenever the output register is empty or taken.
// Reset clears every valid bit and loads the registers with order XYZCT,
// all sizes 1 and image count 1.
module zct_plane_index_mapper_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [zctpim_pkg::CFG_AW-1:0]   cfg_index_i,
  input  logic [zctpim_pkg::CFG_DW-1:0]   cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // z_outer, c_outer, t_outer, z_sub, c_sub, t_sub, plane_index
  input  logic [zctpim_pkg::IN_DW-1:0]    s_axis_tdata_i,
  // action
  input  logic [zctpim_pkg::IN_UW-1:0]    s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // index_out, z_out, c_out, t_out, z_sub_out, c_sub_out, t_sub_out, error_code, pad
  output logic [zctpim_pkg::OUT_DW-1:0]   m_axis_tdata_o
);

  import zctpim_pkg::*;

  logic [2:0]        dim_order_q;
  logic [2:0][SW-1:0] size_q;
  logic [2:0][SW-1:0] sub_q;
  logic [IW-1:0]     count_q;

  slots_t            slots;
  logic [SW-1:0]     len0;
  logic [SW-1:0]     len1;
  logic              en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_order_q <= ORD_XYZCT;
      size_q      <= {3{SW'(1)}};
      sub_q       <= {3{SW'(1)}};
      count_q     <= IW'(1);
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_DIM_ORDER:   dim_order_q   <= cfg_data_i[2:0];
        REG_Z_SIZE:      size_q[DIM_Z] <= cfg_data_i[SW-1:0];
        REG_C_SIZE:      size_q[DIM_C] <= cfg_data_i[SW-1:0];
        REG_T_SIZE:      size_q[DIM_T] <= cfg_data_i[SW-1:0];
        REG_Z_SUB_SIZE:  sub_q[DIM_Z]  <= cfg_data_i[SW-1:0];
        REG_C_SUB_SIZE:  sub_q[DIM_C]  <= cfg_data_i[SW-1:0];
        REG_T_SUB_SIZE:  sub_q[DIM_T]  <= cfg_data_i[SW-1:0];
        REG_IMAGE_COUNT: count_q       <= cfg_data_i[IW-1:0];
        default:         dim_order_q   <= dim_order_q;
      endcase
    end
  end

  assign slots = order_slots(dim_order_q);
  assign len0  = size_q[slots.s0];
  assign len1  = size_q[slots.s1];

  logic               out_v_q;
  logic [OUT_DW-1:0]  out_data_q;
  logic [OUT_DW-1:0]  out_data_d;

  assign en              = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // stage 1: full coordinates and partial size product
  logic [2:0][SW+IW-SW:0] s1_full_d;
  logic [IW-1:0]          s1_p_d;
  logic                   s1_v_q;
  logic                   s1_act_q;
  logic [2:0][IW:0]       s1_full_q;
  logic [IW-1:0]          s1_idx_q;
  logic [IW-1:0]          s1_p_q;

  always_comb begin
    logic [IW-1:0] prod;
    for (int d = 0; d < 3; d++) begin
      prod = IW'(s_axis_tdata_i[SW*d +: SW]) * IW'(sub_q[d]);
      s1_full_d[d] = {1'b0, prod} + {{(IW+1-SW){1'b0}}, s_axis_tdata_i[3*SW + SW*d +: SW]};
    end
    s1_p_d = IW'(size_q[DIM_Z]) * IW'(size_q[DIM_C]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_act_q  <= s_axis_tuser_i[0];
      s1_full_q <= s1_full_d;
      s1_idx_q  <= s_axis_tdata_i[6*SW +: IW];
      s1_p_q    <= s1_p_d;
    end
  end

  // stage 2: size product check, range checks, first index terms
  logic [IW+SW-1:0] s2_prod;
  logic [2:0]       s2_rng_d;
  logic             s2_v_q;
  logic             s2_act_q;
  logic [IW-1:0]    s2_idx_q;
  logic             s2_mism_q;
  logic [2:0]       s2_rng_q;
  logic [IW-1:0]    s2_m1_q;
  logic [IW-1:0]    s2_l01_q;
  logic [SW-1:0]    s2_f0_q;
  logic [SW-1:0]    s2_f2_q;

  always_comb begin
    s2_prod = (IW+SW)'(s1_p_q) * (IW+SW)'(size_q[DIM_T]);
    for (int d = 0; d < 3; d++) begin
      s2_rng_d[d] = s1_full_q[d] >= {{(IW+1-SW){1'b0}}, size_q[d]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_act_q  <= s1_act_q;
      s2_idx_q  <= s1_idx_q;
      s2_mism_q <= s2_prod != {{SW{1'b0}}, count_q};
      s2_rng_q  <= s2_rng_d;
      s2_m1_q   <= IW'(s1_full_q[slots.s1][SW-1:0]) * IW'(len0);
      s2_l01_q  <= IW'(len0) * IW'(len1);
      s2_f0_q   <= s1_full_q[slots.s0][SW-1:0];
      s2_f2_q   <= s1_full_q[slots.s2][SW-1:0];
    end
  end

  // stage 3: error priority and forward index
  logic [IW+SW-1:0] s3_m2;
  side_t            s3_side_d;
  logic             s3_v_q;
  side_t            s3_side_q;
  logic [IW-1:0]    s3_idx_q;

  always_comb begin
    s3_m2 = (IW+SW)'(s2_f2_q) * (IW+SW)'(s2_l01_q);
    s3_side_d.action = s2_act_q;
    s3_side_d.fidx   = {{(IW-SW){1'b0}}, s2_f0_q} + s2_m1_q + s3_m2[IW-1:0];
    if (size_q[DIM_Z] == '0)                            s3_side_d.err = ERR_Z_SIZE;
    else if (size_q[DIM_T] == '0)                       s3_side_d.err = ERR_T_SIZE;
    else if (size_q[DIM_C] == '0)                       s3_side_d.err = ERR_C_SIZE;
    else if (count_q == '0)                             s3_side_d.err = ERR_COUNT;
    else if (s2_mism_q)                                 s3_side_d.err = ERR_MISMATCH;
    else if (s2_act_q == ACT_FORWARD && s2_rng_q[DIM_Z]) s3_side_d.err = ERR_Z_RANGE;
    else if (s2_act_q == ACT_FORWARD && s2_rng_q[DIM_T]) s3_side_d.err = ERR_T_RANGE;
    else if (s2_act_q == ACT_FORWARD && s2_rng_q[DIM_C]) s3_side_d.err = ERR_C_RANGE;
    else                                                s3_side_d.err = ERR_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_side_q <= s3_side_d;
      s3_idx_q  <= s2_idx_q;
    end
  end

  // index split by the two inner sizes
  logic                  d1_v;
  logic [0:0][IW-1:0]    d1_q;
  logic [0:0][SW-1:0]    d1_r;
  side_t                 d1_side;

  zctpim_div #(
    .LANES(1), .DW(IW), .SW(SW), .SIDE_W($bits(side_t))
  ) u_div_len0 (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s3_v_q), .dividend_i(s3_idx_q), .divisor_i(len0),
    .side_i(s3_side_q),
    .valid_o(d1_v), .quot_o(d1_q), .rem_o(d1_r), .side_o(d1_side)
  );

  logic                  d2_v;
  logic [0:0][IW-1:0]    d2_q;
  logic [0:0][SW-1:0]    d2_r;
  side2_t                d2_side;
  side2_t                d2_side_in;

  assign d2_side_in = '{base: d1_side, r1: d1_r[0]};

  zctpim_div #(
    .LANES(1), .DW(IW), .SW(SW), .SIDE_W($bits(side2_t))
  ) u_div_len1 (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(d1_v), .dividend_i(d1_q), .divisor_i(len1),
    .side_i(d2_side_in),
    .valid_o(d2_v), .quot_o(d2_q), .rem_o(d2_r), .side_o(d2_side)
  );

  // full coordinates split by the modulo sizes
  logic [2:0][IW-1:0]    d3_full;
  logic [2:0][SW-1:0]    d3_div;
  logic                  d3_v;
  logic [2:0][IW-1:0]    d3_q;
  logic [2:0][SW-1:0]    d3_r;
  side_t                 d3_side;

  always_comb begin
    d3_full = '0;
    d3_full[slots.s0] = {{(IW-SW){1'b0}}, d2_side.r1};
    d3_full[slots.s1] = {{(IW-SW){1'b0}}, d2_r[0]};
    d3_full[slots.s2] = d2_q[0];
    for (int d = 0; d < 3; d++) begin
      d3_div[d] = (sub_q[d] == '0) ? SW'(1) : sub_q[d];
    end
  end

  zctpim_div #(
    .LANES(3), .DW(IW), .SW(SW), .SIDE_W($bits(side_t))
  ) u_div_sub (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(d2_v), .dividend_i(d3_full), .divisor_i(d3_div),
    .side_i(d2_side.base),
    .valid_o(d3_v), .quot_o(d3_q), .rem_o(d3_r), .side_o(d3_side)
  );

  // output register
  always_comb begin
    out_data_d = '0;
    out_data_d[3*IW+IW+3*SW +: ERRW] = d3_side.err;
    if (d3_side.err == ERR_OK) begin
      if (d3_side.action == ACT_FORWARD) begin
        out_data_d[0 +: IW] = d3_side.fidx;
      end else begin
        for (int d = 0; d < 3; d++) begin
          out_data_d[IW + IW*d +: IW]   = d3_q[d];
          out_data_d[4*IW + SW*d +: SW] = d3_r[d];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= d3_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;

  a_err_clears_fields: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[4*IW+3*SW +: ERRW] != ERR_OK)
      |-> (m_axis_tdata_o[4*IW+3*SW-1:0] == '0)
  ) else $error("fields not cleared on error result");

  a_err_code_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[4*IW+3*SW +: ERRW] <= ERR_C_RANGE)
  ) else $error("error code outside defined set");

  a_forward_no_coords: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (en && d3_v && d3_side.action == ACT_FORWARD)
      |=> (m_axis_tdata_o[4*IW+3*SW-1:IW] == '0)
  ) else $error("forward result carries coordinates");

endmodule

>>> verif/zct_plane_index_mapper_top_test.sv
// Self-checking testbench for the ZCT plane index mapper top level.
// Drives random and directed forward/inverse mapping requests and register
// writes, predicts each result and compares it. Depends on zctpim_pkg and the RTL.
module zct_plane_index_mapper_top_test;
  import zctpim_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CFG_AW-1:0]   cfg_index_i;
  logic [CFG_DW-1:0]   cfg_data_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [IN_DW-1:0]    s_axis_tdata_i;
  logic [IN_UW-1:0]    s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OUT_DW-1:0]   m_axis_tdata_o;

  localparam int PIPE_CYCLES = 100;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [ERRW-1:0] err;
    logic [SW-1:0]   t_sub;
    logic [SW-1:0]   c_sub;
    logic [SW-1:0]   z_sub;
    logic [IW-1:0]   t_pos;
    logic [IW-1:0]   c_pos;
    logic [IW-1:0]   z_pos;
    logic [IW-1:0]   index;
  } mapping_t;

  typedef struct packed {
    logic [IW-1:0] plane_index;
    logic [SW-1:0] t_sub;
    logic [SW-1:0] c_sub;
    logic [SW-1:0] z_sub;
    logic [SW-1:0] t_outer;
    logic [SW-1:0] c_outer;
    logic [SW-1:0] z_outer;
  } coords_t;

  logic [2:0]    order_q;
  logic [63:0]   extent_q[3];
  logic [63:0]   modulo_q[3];
  logic [63:0]   count_q;

  mapping_t      pending_maps[$];
  int            mismatches;
  int            idle_cycles;
  bit            idle_enable;
  bit            hold_off;

  zct_plane_index_mapper_top uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic mapping_t map_request(coords_t c, logic act);
    mapping_t    m;
    slots_t      s;
    logic [63:0] full[3];
    logic [63:0] len0, len1, idx, p;
    int          d[3];
    m = '0;
    s = order_slots(order_q);
    d[0] = int'(s.s0);
    d[1] = int'(s.s1);
    d[2] = int'(s.s2);
    if (extent_q[DIM_Z] == 0) m.err = ERR_Z_SIZE;
    else if (extent_q[DIM_T] == 0) m.err = ERR_T_SIZE;
    else if (extent_q[DIM_C] == 0) m.err = ERR_C_SIZE;
    else if (count_q == 0) m.err = ERR_COUNT;
    else begin
      p = extent_q[DIM_Z] * extent_q[DIM_C];
      if (p > count_q / extent_q[DIM_T] || p * extent_q[DIM_T] != count_q)
        m.err = ERR_MISMATCH;
    end
    if (m.err != ERR_OK) return m;
    len0 = extent_q[d[0]];
    len1 = extent_q[d[1]];
    if (act == ACT_FORWARD) begin
      full[DIM_Z] = 64'(c.z_outer) * modulo_q[DIM_Z] + c.z_sub;
      full[DIM_C] = 64'(c.c_outer) * modulo_q[DIM_C] + c.c_sub;
      full[DIM_T] = 64'(c.t_outer) * modulo_q[DIM_T] + c.t_sub;
      if (full[DIM_Z] >= extent_q[DIM_Z]) m.err = ERR_Z_RANGE;
      else if (full[DIM_T] >= extent_q[DIM_T]) m.err = ERR_T_RANGE;
      else if (full[DIM_C] >= extent_q[DIM_C]) m.err = ERR_C_RANGE;
      if (m.err != ERR_OK) return m;
      m.index = 32'(full[d[0]] + full[d[1]] * len0 + full[d[2]] * len0 * len1);
    end else begin
      idx = 64'(c.plane_index);
      full[d[0]] = idx % len0;
      full[d[1]] = (idx / len0) % len1;
      full[d[2]] = idx / len0 / len1;
      for (int k = 0; k < 3; k++) begin
        if (modulo_q[k] != 0) begin
          p = full[k] % modulo_q[k];
          full[k] = full[k] / modulo_q[k];
        end else p = 0;
        case (k)
          DIM_Z: begin m.z_pos = 32'(full[k]); m.z_sub = 16'(p); end
          DIM_C: begin m.c_pos = 32'(full[k]); m.c_sub = 16'(p); end
          default: begin m.t_pos = 32'(full[k]); m.t_sub = 16'(p); end
        endcase
      end
    end
    return m;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(reg_e r, logic [31:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (r)
      REG_DIM_ORDER:   order_q = v[2:0];
      REG_Z_SIZE:      extent_q[DIM_Z] = v[15:0];
      REG_C_SIZE:      extent_q[DIM_C] = v[15:0];
      REG_T_SIZE:      extent_q[DIM_T] = v[15:0];
      REG_Z_SUB_SIZE:  modulo_q[DIM_Z] = v[15:0];
      REG_C_SUB_SIZE:  modulo_q[DIM_C] = v[15:0];
      REG_T_SUB_SIZE:  modulo_q[DIM_T] = v[15:0];
      default:         count_q = v;
    endcase
  endtask

  task automatic send_request(coords_t c, logic act);
    while (idle_enable && $urandom_range(99) < 12) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    s_axis_tuser_i  <= act;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_maps.insert(pending_maps.size(), map_request(c, act));
  endtask

  task automatic drain;
    s_axis_tvalid_i <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk_i);
    repeat (PIPE_CYCLES + 10) @(posedge clk_i);
  endtask

  // Geometry: sizes z,c,t with sub sizes; the image count is written as given.
  task automatic set_geometry(logic [2:0] ord, logic [15:0] zs, logic [15:0] cs,
                              logic [15:0] ts, logic [15:0] zm, logic [15:0] cm,
                              logic [15:0] tm, logic [31:0] cnt);
    drain();
    write_reg(REG_DIM_ORDER, {$urandom} & ~32'h7 | ord);
    write_reg(REG_Z_SIZE, {$urandom} & 32'hFFFF0000 | zs);
    write_reg(REG_C_SIZE, cs);
    write_reg(REG_T_SIZE, ts);
    write_reg(REG_Z_SUB_SIZE, zm);
    write_reg(REG_C_SUB_SIZE, cm);
    write_reg(REG_T_SUB_SIZE, tm);
    write_reg(REG_IMAGE_COUNT, cnt);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic coords_t random_coords(bit in_range);
    coords_t c;
    c = {$urandom, $urandom, $urandom, $urandom};
    if (in_range) begin
      c.z_sub   = (modulo_q[DIM_Z] > 1) ? 16'($urandom_range(32'(modulo_q[DIM_Z] - 1))) : 16'h0;
      c.c_sub   = (modulo_q[DIM_C] > 1) ? 16'($urandom_range(32'(modulo_q[DIM_C] - 1))) : 16'h0;
      c.t_sub   = (modulo_q[DIM_T] > 1) ? 16'($urandom_range(32'(modulo_q[DIM_T] - 1))) : 16'h0;
      c.z_outer = 16'($urandom_range(32'(extent_q[DIM_Z] /
                                         (modulo_q[DIM_Z] ? modulo_q[DIM_Z] : 1))));
      c.c_outer = 16'($urandom_range(32'(extent_q[DIM_C] /
                                         (modulo_q[DIM_C] ? modulo_q[DIM_C] : 1))));
      c.t_outer = 16'($urandom_range(32'(extent_q[DIM_T] /
                                         (modulo_q[DIM_T] ? modulo_q[DIM_T] : 1))));
      c.plane_index = (count_q != 0 && $urandom_range(9) != 0) ?
                      $urandom_range(32'(count_q - 1)) : $urandom;
    end
    return c;
  endfunction

  task automatic test_directed;
    coords_t c;
    c = '0;
    send_request(c, 1'b0);
    send_request(c, 1'b1);
    c = '1;
    send_request(c, 1'b0);
    send_request(c, 1'b1);
    for (int o = 0; o < 8; o++) begin
      set_geometry(3'(o), 4, 6, 10, 2, 3, 5, 240);
      c = '0;
      c.z_outer = 1; c.z_sub = 1; c.c_outer = 1; c.c_sub = 2; c.t_outer = 1; c.t_sub = 4;
      send_request(c, 1'b0);
      c.plane_index = 239;
      send_request(c, 1'b1);
      c.plane_index = 32'hFFFFFFFF;
      send_request(c, 1'b1);
    end
  endtask

  task automatic test_errors;
    coords_t c;
    c = '0;
    set_geometry(0, 0, 0, 0, 1, 1, 1, 0);
    send_request(c, 1'b0);
    set_geometry(0, 2, 0, 0, 1, 1, 1, 0);
    send_request(c, 1'b1);
    set_geometry(0, 2, 0, 3, 1, 1, 1, 0);
    send_request(c, 1'b0);
    set_geometry(0, 2, 3, 3, 1, 1, 1, 0);
    send_request(c, 1'b1);
    set_geometry(0, 2, 3, 3, 1, 1, 1, 19);
    send_request(c, 1'b0);
    set_geometry(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 1, 32'hFFFE0001);
    send_request(c, 1'b0);
    set_geometry(0, 2, 3, 4, 0, 0, 0, 24);
    c.z_sub = 2; send_request(c, 1'b0);
    c.z_sub = 0; c.t_sub = 4; send_request(c, 1'b0);
    c.t_sub = 0; c.c_sub = 3; send_request(c, 1'b0);
    c.c_sub = 2; c.t_sub = 3; c.z_sub = 1; send_request(c, 1'b0);
    c.plane_index = 23; send_request(c, 1'b1);
  endtask

  task automatic test_random;
    logic [15:0] zs, cs, ts;
    for (int phase = 0; phase < 24; phase++) begin
      idle_enable = (phase % 6) != 3;
      case (phase % 4)
        0: begin zs = 16'hFFFF; cs = 16'hFFFF; ts = 1; end
        1: begin zs = 16'($urandom_range(1, 300)); cs = 16'($urandom_range(1, 200));
                 ts = 16'($urandom_range(1, 60)); end
        2: begin zs = 16'($urandom_range(1, 8)); cs = 16'($urandom_range(1, 8));
                 ts = 16'($urandom_range(1, 8)); end
        default: begin zs = 16'($urandom_range(1, 40000)); cs = 1;
                 ts = 16'($urandom_range(1, 65535)); end
      endcase
      set_geometry(3'($urandom_range(7)), zs, cs, ts,
                   $urandom_range(3) == 0 ? 16'h0 : 16'($urandom_range(1, zs + 1)),
                   $urandom_range(3) == 0 ? 16'h0 : 16'($urandom_range(1, cs + 1)),
                   $urandom_range(5) == 0 ? 16'hFFFF : 16'($urandom_range(1, ts + 1)),
                   $urandom_range(15) == 0 ? $urandom : 32'(zs) * cs * ts);
      if (phase == 5) hold_off = 1'b1;
      for (int n = 0; n < ((phase == 5) ? 160 : 44); n++)
        send_request(random_coords($urandom_range(9) != 0), $urandom_range(1));
    end
    idle_enable = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      idle_cycles     <= 0;
    end else if (hold_off) begin
      m_axis_tready_i <= 1'b0;
      idle_cycles     <= idle_cycles + 1;
      if (idle_cycles == 300) begin
        hold_off    = 1'b0;
        idle_cycles <= 0;
      end
    end else begin
      m_axis_tready_i <= !idle_enable || $urandom_range(99) >= 12;
    end
  end

  always @(posedge clk_i) begin
    mapping_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[$bits(mapping_t)-1:0];
      if (pending_maps.size() == 0) begin
        report_mismatch("unexpected result", got.index, 0);
      end else begin
        want = pending_maps.pop_front();
        if (got.index !== want.index) report_mismatch("index_out", got.index, want.index);
        if (got.z_pos !== want.z_pos) report_mismatch("z_out", got.z_pos, want.z_pos);
        if (got.c_pos !== want.c_pos) report_mismatch("c_out", got.c_pos, want.c_pos);
        if (got.t_pos !== want.t_pos) report_mismatch("t_out", got.t_pos, want.t_pos);
        if (got.z_sub !== want.z_sub) report_mismatch("z_sub_out", got.z_sub, want.z_sub);
        if (got.c_sub !== want.c_sub) report_mismatch("c_sub_out", got.c_sub, want.c_sub);
        if (got.t_sub !== want.t_sub) report_mismatch("t_sub_out", got.t_sub, want.t_sub);
        if (got.err !== want.err) report_mismatch("error_code", got.err, want.err);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o) || hold_off)
        quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_DIM_ORDER;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    mismatches      = 0;
    idle_enable     = 1'b1;
    hold_off        = 1'b0;
    order_q         = ORD_XYZCT;
    count_q         = 1;
    for (int k = 0; k < 3; k++) begin
      extent_q[k] = 1;
      modulo_q[k] = 1;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_errors();
    test_random();
    drain();
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/zctpim_pkg.sv
rtl/zctpim_div.sv
rtl/zct_plane_index_mapper_top.sv
verif/zct_plane_index_mapper_top_test.sv
